### hdl/lcae_pkg.sv
package lcae_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = 6;
    localparam int ROW_W    = 6;
    localparam int DIM_W    = 7;
    localparam int CNT_W    = 13;
    localparam int NBR_W    = 4;

    localparam logic [NBR_W-1:0] SURVIVE_MIN = NBR_W'(2);
    localparam logic [NBR_W-1:0] BIRTH_COUNT = NBR_W'(3);

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] COLS_LIMIT = DIM_W'(MAX_COLS);
    localparam logic [DIM_W-1:0] ROWS_LIMIT = DIM_W'(MAX_ROWS);

    // Three-cell columns of the window, ordered row above, own row, row below.
    typedef struct packed {
        logic [2:0] lft;
        logic [2:0] ctr;
        logic [2:0] rgt;
    } t_nbhd;

    typedef struct packed {
        logic nxt;
        logic born;
        logic died;
    } t_cell_res;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] res;
        begin
            if (v == '0) begin
                res = DIM_W'(1);
            end else if (v > lim) begin
                res = lim;
            end else begin
                res = v;
            end
            return res;
        end
    endfunction

    function automatic logic [MAX_COLS-1:0] width_mask(input logic [DIM_W-1:0] w);
        logic [MAX_COLS-1:0] m;
        begin
            for (int i = 0; i < MAX_COLS; i++) begin
                m[i] = (DIM_W'(i) < w);
            end
            return m;
        end
    endfunction

endpackage

### hdl/lcae_next_cell.sv
module lcae_next_cell (
    input  lcae_pkg::t_nbhd     i_nbhd,
    output lcae_pkg::t_cell_res o_res
);

    logic [lcae_pkg::NBR_W-1:0] nbr_cnt;
    logic                       cur;

    assign cur = i_nbhd.ctr[1];

    assign nbr_cnt = lcae_pkg::NBR_W'(i_nbhd.lft[0]) + lcae_pkg::NBR_W'(i_nbhd.lft[1])
                   + lcae_pkg::NBR_W'(i_nbhd.lft[2]) + lcae_pkg::NBR_W'(i_nbhd.ctr[0])
                   + lcae_pkg::NBR_W'(i_nbhd.ctr[2]) + lcae_pkg::NBR_W'(i_nbhd.rgt[0])
                   + lcae_pkg::NBR_W'(i_nbhd.rgt[1]) + lcae_pkg::NBR_W'(i_nbhd.rgt[2]);

    always_comb begin
        o_res.died = cur && ((nbr_cnt < lcae_pkg::SURVIVE_MIN) ||
                             (nbr_cnt > lcae_pkg::BIRTH_COUNT));
        o_res.born = !cur && (nbr_cnt == lcae_pkg::BIRTH_COUNT);
        o_res.nxt  = (cur && !o_res.died) || o_res.born;
    end

endmodule

### hdl/life_cellular_automaton_engine_unit.sv
// Cell write or read: the row is fetched, then written or sampled in ST_ACC, and the result
// item is loaded in ST_DONE; outside the grid the item goes straight to ST_DONE. Step: one
// cell is evaluated per cycle by the shared neighbor unit; each row adds write-back and load states.
// One item is worked on at a time; a new item is taken while a result still waits.
// Reset clears the per-row valid bits, so the whole grid reads dead at once with
// no clearing pass, and sets both grid dimensions to 64.
module life_cellular_automaton_engine_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [lcae_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_opcode,
    input  logic [lcae_pkg::COL_W-1:0]     i_col,
    input  logic [lcae_pkg::ROW_W-1:0]     i_row,
    input  logic                           i_alive,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_cell_state,
    output logic [lcae_pkg::CNT_W-1:0]     o_births,
    output logic [lcae_pkg::CNT_W-1:0]     o_deaths,
    output logic                           o_range_error
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_ACC     = 7'b0000010,
        ST_LD0     = 7'b0000100,
        ST_LD1     = 7'b0001000,
        ST_CELL    = 7'b0010000,
        ST_ROW_END = 7'b0100000,
        ST_DONE    = 7'b1000000
    } t_state;

    localparam int MC = lcae_pkg::MAX_COLS;
    localparam int MR = lcae_pkg::MAX_ROWS;

    t_state r_state, n_state;

    logic [lcae_pkg::DIM_W-1:0] r_width, r_height;

    logic [MC-1:0]                r_mem [MR];
    logic [MR-1:0]                r_row_vld;
    logic [MC-1:0]                r_rd_data;
    logic                         r_rd_vld;
    logic                         mem_re, mem_we;
    logic [lcae_pkg::ROW_W-1:0]   mem_raddr, mem_waddr;
    logic [MC-1:0]                mem_wdata;
    logic [MC-1:0]                row_eff, wmask, acc_row;

    logic [1:0]                   r_op;
    logic [lcae_pkg::COL_W-1:0]   r_col;
    logic [lcae_pkg::ROW_W-1:0]   r_row;
    logic                         r_alive;

    logic [MC-1:0]                r_up, r_mid, r_dn, r_mid_raw, r_dn_raw, r_new;
    logic [2:0]                   r_lft;
    logic [lcae_pkg::COL_W-1:0]   r_ccnt;
    logic [lcae_pkg::ROW_W-1:0]   r_rcnt;
    logic [lcae_pkg::CNT_W-1:0]   r_births, r_deaths;
    logic                         r_pend_cell, r_pend_err;

    logic                         accept, in_range, out_load, last_col, last_row, dn_exists;
    lcae_pkg::t_nbhd              nbhd;
    lcae_pkg::t_cell_res          cres;

    assign o_ready   = (r_state == ST_IDLE);
    assign accept    = i_valid && o_ready;
    assign in_range  = ({1'b0, i_col} < r_width) && ({1'b0, i_row} < r_height);
    assign row_eff   = r_rd_vld ? r_rd_data : '0;
    assign wmask     = lcae_pkg::width_mask(r_width);
    assign last_col  = ({1'b0, r_ccnt} == (r_width - lcae_pkg::DIM_W'(1)));
    assign last_row  = ({1'b0, r_rcnt} == (r_height - lcae_pkg::DIM_W'(1)));
    assign dn_exists = (({1'b0, r_rcnt} + lcae_pkg::DIM_W'(1)) < r_height);
    assign out_load  = (r_state == ST_DONE) && (!o_valid || i_ready);

    assign nbhd.lft = r_lft;
    assign nbhd.ctr = {r_up[0], r_mid[0], r_dn[0]};
    assign nbhd.rgt = {r_up[1], r_mid[1], r_dn[1]};

    lcae_next_cell u_next_cell (
        .i_nbhd (nbhd),
        .o_res  (cres)
    );

    always_comb begin
        acc_row        = row_eff;
        acc_row[r_col] = r_alive;
    end

    always_comb begin
        n_state   = r_state;
        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = r_rcnt;
        mem_wdata = r_new;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_opcode inside {lcae_pkg::OP_WRITE, lcae_pkg::OP_READ}) begin
                        if (in_range) begin
                            mem_re    = 1'b1;
                            mem_raddr = i_row;
                            n_state   = ST_ACC;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end else if (i_opcode == lcae_pkg::OP_STEP) begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        n_state   = ST_LD0;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_ACC: begin
                if (r_op == lcae_pkg::OP_WRITE) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_row;
                    mem_wdata = acc_row;
                end
                n_state = ST_DONE;
            end
            ST_LD0: begin
                mem_re    = 1'b1;
                mem_raddr = lcae_pkg::ROW_W'(1);
                n_state   = ST_LD1;
            end
            ST_LD1: begin
                n_state = ST_CELL;
            end
            ST_CELL: begin
                if (last_col) begin
                    n_state = ST_ROW_END;
                end
            end
            ST_ROW_END: begin
                mem_we = 1'b1;
                if (last_row) begin
                    n_state = ST_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_rcnt + lcae_pkg::ROW_W'(2);
                    n_state   = ST_LD1;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_width   <= lcae_pkg::COLS_LIMIT;
            r_height  <= lcae_pkg::ROWS_LIMIT;
            r_row_vld <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == lcae_pkg::CFG_WIDTH) begin
                    r_width <= lcae_pkg::clamp_dim(i_cfg_data, lcae_pkg::COLS_LIMIT);
                end else if (i_cfg_idx == lcae_pkg::CFG_HEIGHT) begin
                    r_height <= lcae_pkg::clamp_dim(i_cfg_data, lcae_pkg::ROWS_LIMIT);
                end
            end
            if (mem_we) begin
                r_row_vld[mem_waddr] <= 1'b1;
            end
            if (out_load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
            r_rd_vld  <= r_row_vld[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_op        <= i_opcode;
                    r_col       <= i_col;
                    r_row       <= i_row;
                    r_alive     <= i_alive;
                    r_births    <= '0;
                    r_deaths    <= '0;
                    r_pend_cell <= 1'b0;
                    r_pend_err  <= (i_opcode inside {lcae_pkg::OP_WRITE, lcae_pkg::OP_READ})
                                   && !in_range;
                end
            end
            ST_ACC: begin
                if (r_op == lcae_pkg::OP_READ) begin
                    r_pend_cell <= row_eff[r_col];
                end
            end
            ST_LD0: begin
                r_up      <= '0;
                r_mid     <= row_eff & wmask;
                r_mid_raw <= row_eff;
                r_new     <= row_eff;
                r_rcnt    <= '0;
            end
            ST_LD1: begin
                r_dn     <= dn_exists ? (row_eff & wmask) : '0;
                r_dn_raw <= row_eff;
                r_ccnt   <= '0;
                r_lft    <= '0;
            end
            ST_CELL: begin
                r_new[r_ccnt] <= cres.nxt;
                if (cres.born && (r_births != '1)) begin
                    r_births <= r_births + lcae_pkg::CNT_W'(1);
                end
                if (cres.died && (r_deaths != '1)) begin
                    r_deaths <= r_deaths + lcae_pkg::CNT_W'(1);
                end
                r_lft  <= nbhd.ctr;
                r_up   <= r_up >> 1;
                r_mid  <= r_mid >> 1;
                r_dn   <= r_dn >> 1;
                r_ccnt <= r_ccnt + lcae_pkg::COL_W'(1);
            end
            ST_ROW_END: begin
                if (!last_row) begin
                    r_up      <= r_mid_raw & wmask;
                    r_mid     <= r_dn_raw & wmask;
                    r_mid_raw <= r_dn_raw;
                    r_new     <= r_dn_raw;
                    r_rcnt    <= r_rcnt + lcae_pkg::ROW_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (out_load) begin
            o_cell_state  <= r_pend_cell;
            o_range_error <= r_pend_err;
            o_births      <= r_births;
            o_deaths      <= r_deaths;
        end
    end

    a_col_in_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CELL) |-> ({1'b0, r_ccnt} < r_width))
        else $error("column counter ran past the grid width");

    a_row_in_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROW_END) |-> ({1'b0, r_rcnt} < r_height))
        else $error("row counter ran past the grid height");

    a_err_no_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_range_error && ((o_births != '0) || (o_deaths != '0))))
        else $error("range error item carries step counts");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready stayed high after an item was accepted");

endmodule
